// ===== rtl/piug_pkg.sv =====
// Package for the patch unfold index generator.
// Holds field widths, register codes and reset values; no dependencies.
package piug_pkg;

   // Limits on the clamped configuration
   localparam int unsigned MaxKernel   = 16;
   localparam int unsigned MaxChannels = 64;
   localparam int unsigned MaxDim      = 1024;

   // Register field widths
   localparam int unsigned KernelW  = 5;
   localparam int unsigned ChanCntW = 7;
   localparam int unsigned DimW     = 11;

   // Payload widths
   localparam int unsigned PixelW   = 32;
   localparam int unsigned ImageW   = 16;
   localparam int unsigned PRowW    = 14;
   localparam int unsigned PColW    = 20;

   // Position counter widths
   localparam int unsigned PosW     = 10;
   localparam int unsigned ChanPosW = 6;
   localparam int unsigned OffW     = 4;

   // Configuration port
   localparam int unsigned AddrW    = 4;
   localparam int unsigned DataW    = 32;

   typedef enum logic [1:0] {
      REG_KERNEL_SIZE   = 2'd0,
      REG_CHANNEL_COUNT = 2'd1,
      REG_IMAGE_HEIGHT  = 2'd2,
      REG_IMAGE_WIDTH   = 2'd3
   } reg_index_type;

   localparam logic [KernelW-1:0]  KernelReset  = 5'd4;
   localparam logic [ChanCntW-1:0] ChanCntReset = 7'd3;
   localparam logic [DimW-1:0]     HeightReset  = 11'd32;
   localparam logic [DimW-1:0]     WidthReset   = 11'd32;

endpackage

// ===== rtl/patch_unfold_index_generator.sv =====
// Patch unfold index generator: top level, single module.
// Depends on piug_pkg for widths, register codes and reset values.
//   Pixels enter on the req_ channel in raster order (column, row, channel,
//   image), one transfer per pixel. Each pixel yields one transfer on the
//   rsp_ channel with the pixel word, a keep flag, the destination row and
//   column of the non-overlapping patch layout, the image index and an
//   end-of-image flag.
//   The result is registered: an accepted pixel is offered on rsp_ from the
//   next cycle. Throughput is one pixel per cycle while rsp_ is not stalled;
//   the position counters advance in one step and the result goes to a single
//   output register.
//   req_stall is high only while the output register holds a result and the
//   receiver stalls it, so the block takes a new pixel in the same cycle the
//   held result is taken. A stalled result stays unchanged.
//   The csr_ port holds kernel size, channel count, image height and image
//   width at byte addresses 0, 4, 8 and 12. Any write restarts the position
//   counters so the next pixel is the first pixel of an image; the image
//   index keeps counting. Out-of-range values are clamped on use.
//   Synchronous reset empties the output register, restores the register
//   defaults (k=4, 3 channels, 32x32) and clears all counters.
module patch_unfold_index_generator
   import piug_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // pixel input
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PixelW-1:0] req_pixel_value,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PixelW-1:0] rsp_pixel_out,
   output logic              rsp_keep,
   output logic [ImageW-1:0] rsp_image_index,
   output logic [PRowW-1:0]  rsp_patch_row,
   output logic [PColW-1:0]  rsp_patch_column,
   output logic              rsp_end_of_image,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [AddrW-1:0]  csr_paddr,
   input  logic [DataW-1:0]  csr_pwdata,
   output logic [DataW-1:0]  csr_prdata,
   output logic              csr_pready
);

   // Configuration registers
   logic [KernelW-1:0]  kernel_size_ff;
   logic [ChanCntW-1:0] channel_count_ff;
   logic [DimW-1:0]     image_height_ff;
   logic [DimW-1:0]     image_width_ff;

   // Position state
   logic [PosW-1:0]     col_pos_ff, col_pos_in;
   logic [PosW-1:0]     row_pos_ff, row_pos_in;
   logic [ChanPosW-1:0] chan_pos_ff, chan_pos_in;
   logic [ImageW-1:0]   image_count_ff, image_count_in;
   logic [OffW-1:0]     in_patch_col_ff, in_patch_col_in;
   logic [OffW-1:0]     in_patch_row_ff, in_patch_row_in;
   logic [PosW-1:0]     tile_col_ff, tile_col_in;
   logic [PColW-1:0]    tile_row_base_ff, tile_row_base_in;
   logic [PRowW-1:0]    chan_base_ff, chan_base_in;
   logic [DimW-1:0]     row_tiles_ff, row_tiles_in;

   // Output register
   logic                rsp_valid_ff;
   logic [PixelW-1:0]   pixel_out_ff;
   logic                keep_ff, keep_in;
   logic [ImageW-1:0]   image_index_ff;
   logic [PRowW-1:0]    patch_row_ff, patch_row_in;
   logic [PColW-1:0]    patch_column_ff, patch_column_in;
   logic                end_of_image_ff, end_of_image_in;

   logic                cfg_write;
   reg_index_type       cfg_index;
   logic                req_accept;
   logic                rsp_take;

   // Clamped configuration
   logic [KernelW-1:0]  k_eff;
   logic [ChanCntW-1:0] nch_eff;
   logic [DimW-1:0]     h_eff;
   logic [DimW-1:0]     w_eff;

   logic                last_col, last_row, last_chan;
   logic [DimW:0]       tile_x, tile_y;
   logic                keep_col, keep_row;
   logic [8:0]          row_offset;
   logic [8:0]          k_square;
   logic [KernelW-1:0]  ipc_inc, ipr_inc;
   logic                ipc_wrap, ipr_wrap;
   logic [DimW-1:0]     row_tiles_now;

   // Handshake
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = reg_index_type'(csr_paddr[AddrW-1:2]);
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_pready = 1'b1;

   // Register readback
   always_comb begin
      csr_prdata = '0;
      case (cfg_index)
         REG_KERNEL_SIZE:   csr_prdata = DataW'(kernel_size_ff);
         REG_CHANNEL_COUNT: csr_prdata = DataW'(channel_count_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = DataW'(image_height_ff);
         REG_IMAGE_WIDTH:   csr_prdata = DataW'(image_width_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Clamp registers to their legal ranges
   always_comb begin
      k_eff = kernel_size_ff;
      if (kernel_size_ff == '0) k_eff = KernelW'(1);
      else if (kernel_size_ff > KernelW'(MaxKernel)) k_eff = KernelW'(MaxKernel);
      nch_eff = channel_count_ff;
      if (channel_count_ff == '0) nch_eff = ChanCntW'(1);
      else if (channel_count_ff > ChanCntW'(MaxChannels)) nch_eff = ChanCntW'(MaxChannels);
      h_eff = image_height_ff;
      if (image_height_ff == '0) h_eff = DimW'(1);
      else if (image_height_ff > DimW'(MaxDim)) h_eff = DimW'(MaxDim);
      w_eff = image_width_ff;
      if (image_width_ff == '0) w_eff = DimW'(1);
      else if (image_width_ff > DimW'(MaxDim)) w_eff = DimW'(MaxDim);
   end

   // Result fields and position flags
   always_comb begin
      last_col  = {1'b0, col_pos_ff} >= (w_eff - DimW'(1));
      last_row  = {1'b0, row_pos_ff} >= (h_eff - DimW'(1));
      last_chan = {1'b0, chan_pos_ff} >= (nch_eff - ChanCntW'(1));

      // a pixel is kept when the patch it starts in fits inside the plane
      tile_x   = {2'b0, col_pos_ff} - {{(DimW+1-OffW){1'b0}}, in_patch_col_ff};
      tile_y   = {2'b0, row_pos_ff} - {{(DimW+1-OffW){1'b0}}, in_patch_row_ff};
      keep_col = (tile_x + {{(DimW+1-KernelW){1'b0}}, k_eff}) <= {1'b0, w_eff};
      keep_row = (tile_y + {{(DimW+1-KernelW){1'b0}}, k_eff}) <= {1'b0, h_eff};
      keep_in  = keep_col && keep_row;

      row_offset = {5'b0, in_patch_row_ff} * {4'b0, k_eff};
      k_square   = {4'b0, k_eff} * {4'b0, k_eff};

      patch_row_in    = '0;
      patch_column_in = '0;
      if (keep_in) begin
         patch_row_in    = chan_base_ff + PRowW'(row_offset) + PRowW'(in_patch_col_ff);
         patch_column_in = tile_row_base_ff + PColW'(tile_col_ff);
      end
      end_of_image_in = last_col && last_row && last_chan;

      ipc_inc  = {1'b0, in_patch_col_ff} + KernelW'(1);
      ipr_inc  = {1'b0, in_patch_row_ff} + KernelW'(1);
      ipc_wrap = ipc_inc >= k_eff;
      ipr_wrap = ipr_inc >= k_eff;

      // whole patches per row, counted as the row streams past
      row_tiles_now = row_tiles_ff + DimW'(keep_col && ipc_wrap);
   end

   // Advance position counters
   always_comb begin
      col_pos_in       = col_pos_ff;
      row_pos_in       = row_pos_ff;
      chan_pos_in      = chan_pos_ff;
      image_count_in   = image_count_ff;
      in_patch_col_in  = in_patch_col_ff;
      in_patch_row_in  = in_patch_row_ff;
      tile_col_in      = tile_col_ff;
      tile_row_base_in = tile_row_base_ff;
      chan_base_in     = chan_base_ff;
      row_tiles_in     = row_tiles_ff;
      if (!last_col) begin
         col_pos_in   = col_pos_ff + PosW'(1);
         row_tiles_in = row_tiles_now;
         if (ipc_wrap) begin
            in_patch_col_in = '0;
            tile_col_in     = tile_col_ff + PosW'(1);
         end else begin
            in_patch_col_in = OffW'(ipc_inc);
         end
      end else begin
         col_pos_in      = '0;
         in_patch_col_in = '0;
         tile_col_in     = '0;
         row_tiles_in    = '0;
         if (!last_row) begin
            row_pos_in = row_pos_ff + PosW'(1);
            if (ipr_wrap) begin
               in_patch_row_in  = '0;
               tile_row_base_in = tile_row_base_ff + PColW'(row_tiles_now);
            end else begin
               in_patch_row_in = OffW'(ipr_inc);
            end
         end else begin
            row_pos_in       = '0;
            in_patch_row_in  = '0;
            tile_row_base_in = '0;
            if (!last_chan) begin
               chan_pos_in  = chan_pos_ff + ChanPosW'(1);
               chan_base_in = chan_base_ff + PRowW'(k_square);
            end else begin
               chan_pos_in    = '0;
               chan_base_in   = '0;
               image_count_in = image_count_ff + ImageW'(1);
            end
         end
      end
   end

   // Hold configuration and position state
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff   <= KernelReset;
         channel_count_ff <= ChanCntReset;
         image_height_ff  <= HeightReset;
         image_width_ff   <= WidthReset;
         col_pos_ff       <= '0;
         row_pos_ff       <= '0;
         chan_pos_ff      <= '0;
         image_count_ff   <= '0;
         in_patch_col_ff  <= '0;
         in_patch_row_ff  <= '0;
         tile_col_ff      <= '0;
         tile_row_base_ff <= '0;
         chan_base_ff     <= '0;
         row_tiles_ff     <= '0;
      end else if (cfg_write) begin
         case (cfg_index)
            REG_KERNEL_SIZE:   kernel_size_ff   <= csr_pwdata[KernelW-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[ChanCntW-1:0];
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_pwdata[DimW-1:0];
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_pwdata[DimW-1:0];
            default:           kernel_size_ff   <= kernel_size_ff;
         endcase
         // restart at the first pixel of an image
         col_pos_ff       <= '0;
         row_pos_ff       <= '0;
         chan_pos_ff      <= '0;
         in_patch_col_ff  <= '0;
         in_patch_row_ff  <= '0;
         tile_col_ff      <= '0;
         tile_row_base_ff <= '0;
         chan_base_ff     <= '0;
         row_tiles_ff     <= '0;
      end else if (req_accept) begin
         col_pos_ff       <= col_pos_in;
         row_pos_ff       <= row_pos_in;
         chan_pos_ff      <= chan_pos_in;
         image_count_ff   <= image_count_in;
         in_patch_col_ff  <= in_patch_col_in;
         in_patch_row_ff  <= in_patch_row_in;
         tile_col_ff      <= tile_col_in;
         tile_row_base_ff <= tile_row_base_in;
         chan_base_ff     <= chan_base_in;
         row_tiles_ff     <= row_tiles_in;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load result payload on each accepted transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pixel_out_ff    <= req_pixel_value;
         keep_ff         <= keep_in;
         image_index_ff  <= image_count_ff;
         patch_row_ff    <= patch_row_in;
         patch_column_ff <= patch_column_in;
         end_of_image_ff <= end_of_image_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = pixel_out_ff;
   assign rsp_keep         = keep_ff;
   assign rsp_image_index  = image_index_ff;
   assign rsp_patch_row    = patch_row_ff;
   assign rsp_patch_column = patch_column_ff;
   assign rsp_end_of_image = end_of_image_ff;

endmodule

// ===== sim/tb.sv =====
// Testbench for patch_unfold_index_generator: random pixel streams over many
// patch geometries, each result checked against a built-in position tracker.
// Depends on piug_pkg and the RTL top level only.
module tb;
   import piug_pkg::*;

   typedef struct packed {
      logic [PixelW-1:0] pixel;
      logic              keep;
      logic [ImageW-1:0] image;
      logic [PRowW-1:0]  prow;
      logic [PColW-1:0]  pcol;
      logic              eoi;
   } patch_entry_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [PixelW-1:0] req_pixel_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PixelW-1:0] rsp_pixel_out;
   logic              rsp_keep;
   logic [ImageW-1:0] rsp_image_index;
   logic [PRowW-1:0]  rsp_patch_row;
   logic [PColW-1:0]  rsp_patch_column;
   logic              rsp_end_of_image;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [AddrW-1:0]  csr_paddr = '0;
   logic [DataW-1:0]  csr_pwdata = '0;
   logic [DataW-1:0]  csr_prdata;
   logic              csr_pready;

   // pixels waiting to be sent and patch entries waiting to come back
   logic [PixelW-1:0] pending_pixels[$];
   patch_entry_type   expected_entries[$];
   patch_entry_type   head_entry;

   // shadow copy of the geometry registers
   logic [KernelW-1:0]  shadow_kernel = KernelReset;
   logic [ChanCntW-1:0] shadow_chans  = ChanCntReset;
   logic [DimW-1:0]     shadow_height = HeightReset;
   logic [DimW-1:0]     shadow_width  = WidthReset;

   // tracked raster position
   int unsigned       col_at = 0, row_at = 0, plane_at = 0;
   int unsigned       off_col = 0, off_row = 0, patch_x = 0;
   int unsigned       patch_row_base = 0, plane_base = 0;
   logic [ImageW-1:0] images_seen = '0;

   int unsigned src_idle_pct = 0, sink_idle_pct = 0;
   int unsigned src_gap = 0, sink_gap = 0;
   int unsigned fail_count = 0;
   logic        req_taken;

   patch_unfold_index_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_keep         (rsp_keep),
      .rsp_image_index  (rsp_image_index),
      .rsp_patch_row    (rsp_patch_row),
      .rsp_patch_column (rsp_patch_column),
      .rsp_end_of_image (rsp_end_of_image),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                               input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Work out the patch entry for one pixel, then advance the raster position
   task automatic track_pixel(input logic [PixelW-1:0] pix);
      int unsigned     k, nch, h, w, per_row, per_col;
      bit              row_end, plane_end, last_plane, kept;
      patch_entry_type e;
      k   = clamp_range(shadow_kernel, 1, MaxKernel);
      nch = clamp_range(shadow_chans, 1, MaxChannels);
      h   = clamp_range(shadow_height, 1, MaxDim);
      w   = clamp_range(shadow_width, 1, MaxDim);
      per_row    = w / k;
      per_col    = h / k;
      row_end    = col_at >= w - 1;
      plane_end  = row_at >= h - 1;
      last_plane = plane_at >= nch - 1;
      kept       = col_at < per_row * k && row_at < per_col * k;
      e.pixel = pix;
      e.keep  = kept;
      e.image = images_seen;
      e.prow  = kept ? PRowW'(plane_base + off_row * k + off_col) : '0;
      e.pcol  = kept ? PColW'(patch_row_base + patch_x) : '0;
      e.eoi   = row_end && plane_end && last_plane;
      expected_entries.push_back(e);

      if (!row_end) begin
         col_at++;
         off_col++;
         if (off_col >= k) begin
            off_col = 0;
            patch_x++;
         end
      end else begin
         col_at  = 0;
         off_col = 0;
         patch_x = 0;
         if (!plane_end) begin
            row_at++;
            off_row++;
            if (off_row >= k) begin
               off_row = 0;
               patch_row_base = (patch_row_base + per_row) & 32'hFFFFF;
            end
         end else begin
            row_at = 0;
            off_row = 0;
            patch_row_base = 0;
            if (!last_plane) begin
               plane_at++;
               plane_base = (plane_base + k * k) & 32'h3FFF;
            end else begin
               plane_at = 0;
               plane_base = 0;
               images_seen++;
            end
         end
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   // Write one register; in some writes the upper bits outside every field get random noise
   task automatic csr_write(input reg_index_type idx, input logic [DataW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value | (($urandom_range(0, 3) == 0) ? ($urandom << 11) : 32'd0);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_KERNEL_SIZE:   shadow_kernel = value[KernelW-1:0];
         REG_CHANNEL_COUNT: shadow_chans  = value[ChanCntW-1:0];
         REG_IMAGE_HEIGHT:  shadow_height = value[DimW-1:0];
         REG_IMAGE_WIDTH:   shadow_width  = value[DimW-1:0];
         default:           shadow_kernel = shadow_kernel;
      endcase
      // any write restarts the raster position
      col_at = 0; row_at = 0; plane_at = 0;
      off_col = 0; off_row = 0; patch_x = 0;
      patch_row_base = 0; plane_base = 0;
   endtask

   task automatic csr_read_check(input reg_index_type idx, input logic [DataW-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register readback", csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic verify_registers();
      csr_read_check(REG_KERNEL_SIZE, DataW'(shadow_kernel));
      csr_read_check(REG_CHANNEL_COUNT, DataW'(shadow_chans));
      csr_read_check(REG_IMAGE_HEIGHT, DataW'(shadow_height));
      csr_read_check(REG_IMAGE_WIDTH, DataW'(shadow_width));
   endtask

   // Wait until every pixel is sent and every entry has come back
   task automatic wait_drained();
      int unsigned spins;
      while (pending_pixels.size() != 0) @(posedge clock);
      spins = 0;
      while (expected_entries.size() != 0 && spins < 1000) begin
         @(posedge clock);
         spins++;
      end
      if (expected_entries.size() != 0) begin
         $display("%0t: %0d expected patch entries never arrived", $time,
                  expected_entries.size());
         fail_count++;
         expected_entries.delete();
      end
      repeat (2) @(posedge clock);
   endtask

   // Pixel driver: hold a stalled transfer, otherwise send the next pixel or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            track_pixel(req_pixel_value);
            void'(pending_pixels.pop_front());
         end
         if (req_valid && !req_taken) begin
            // keep the payload steady
         end else if (src_gap != 0) begin
            src_gap--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0 && src_idle_pct != 0 &&
                      $urandom_range(1, 100) <= src_idle_pct) begin
            src_gap = $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            req_valid       <= 1'b1;
            req_pixel_value <= pending_pixels[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: compare each transfer with the oldest expected entry
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_entries.size() == 0) begin
               $display("%0t: unexpected result, expected none, got pixel 0x%0h", $time,
                        rsp_pixel_out);
               fail_count++;
            end else begin
               head_entry = expected_entries.pop_front();
               check_field("pixel_out", rsp_pixel_out, head_entry.pixel);
               check_field("keep", rsp_keep, head_entry.keep);
               check_field("image_index", rsp_image_index, head_entry.image);
               check_field("patch_row", rsp_patch_row, head_entry.prow);
               check_field("patch_column", rsp_patch_column, head_entry.pcol);
               check_field("end_of_image", rsp_end_of_image, head_entry.eoi);
            end
         end
         // stall in bursts of random length
         if (sink_gap != 0) begin
            sink_gap--;
            rsp_stall <= 1'b1;
         end else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
            sink_gap = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int unsigned random_items, n, image_px, pick;
      logic [3:0]  which;
      logic [PixelW-1:0] pix;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset geometry, extreme pixel words
      verify_registers();
      pending_pixels.push_back(32'h0000_0000);
      pending_pixels.push_back(32'hFFFF_FFFF);
      pending_pixels.push_back(32'hA5A5_A5A5);
      wait_drained();

      // Directed: 3x3 planes with k=2 leave a leftover row and column
      csr_write(REG_KERNEL_SIZE, 2);
      csr_write(REG_CHANNEL_COUNT, 2);
      csr_write(REG_IMAGE_HEIGHT, 3);
      csr_write(REG_IMAGE_WIDTH, 3);
      verify_registers();
      for (int i = 0; i < 18; i++) pending_pixels.push_back(32'h0101_0101 * i);
      wait_drained();

      // Directed: kernel larger than the image, no whole patch
      csr_write(REG_KERNEL_SIZE, 3);
      csr_write(REG_CHANNEL_COUNT, 1);
      csr_write(REG_IMAGE_HEIGHT, 2);
      csr_write(REG_IMAGE_WIDTH, 2);
      for (int i = 0; i < 4; i++) pending_pixels.push_back($urandom);
      wait_drained();

      // Random geometries, each phase rewriting a random subset of registers
      random_items = 0;
      while (random_items < 780) begin
         pick = $urandom_range(0, 2);
         src_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : 20;
         pick = $urandom_range(0, 2);
         sink_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : 20;
         which = 4'($urandom_range(1, 15));
         if (which[0]) begin
            case ($urandom_range(0, 9))
               0:       n = 0;
               1:       n = MaxKernel;
               2:       n = $urandom_range(17, 31);
               default: n = $urandom_range(1, 5);
            endcase
            csr_write(REG_KERNEL_SIZE, n);
         end
         if (which[1]) begin
            case ($urandom_range(0, 9))
               0:       n = 0;
               1:       n = MaxChannels;
               2:       n = $urandom_range(65, 127);
               default: n = $urandom_range(1, 4);
            endcase
            csr_write(REG_CHANNEL_COUNT, n);
         end
         if (which[2]) begin
            case ($urandom_range(0, 11))
               0:       n = 0;
               1:       n = MaxDim;
               2:       n = $urandom_range(1025, 2047);
               3:       n = $urandom_range(16, 18);
               default: n = $urandom_range(1, 8);
            endcase
            csr_write(REG_IMAGE_HEIGHT, n);
         end
         if (which[3]) begin
            case ($urandom_range(0, 11))
               0:       n = 0;
               1:       n = MaxDim;
               2:       n = $urandom_range(1025, 2047);
               3:       n = $urandom_range(16, 18);
               default: n = $urandom_range(1, 8);
            endcase
            csr_write(REG_IMAGE_WIDTH, n);
         end
         verify_registers();

         // size the phase so small images complete, large ones stay short
         image_px = clamp_range(shadow_width, 1, MaxDim) *
                    clamp_range(shadow_height, 1, MaxDim) *
                    clamp_range(shadow_chans, 1, MaxChannels);
         if (image_px <= 40) n = image_px * $urandom_range(1, 2) + $urandom_range(0, 2);
         else if (image_px <= 400) n = image_px + $urandom_range(0, 2);
         else n = $urandom_range(10, 60);
         if (random_items + n > 780) n = 780 - random_items;
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
               0:       pix = '0;
               1:       pix = '1;
               default: pix = $urandom;
            endcase
            pending_pixels.push_back(pix);
         end
         random_items += n;
         wait_drained();
      end

      // Final part without idling: a run of one-pixel images
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      csr_write(REG_KERNEL_SIZE, 1);
      csr_write(REG_CHANNEL_COUNT, 1);
      csr_write(REG_IMAGE_HEIGHT, 1);
      csr_write(REG_IMAGE_WIDTH, 1);
      verify_registers();
      for (int i = 0; i < 8; i++) pending_pixels.push_back($urandom);
      wait_drained();

      // Final part: one whole small image and the start of the next
      csr_write(REG_KERNEL_SIZE, 2);
      csr_write(REG_CHANNEL_COUNT, 2);
      csr_write(REG_IMAGE_HEIGHT, 4);
      csr_write(REG_IMAGE_WIDTH, 5);
      for (int i = 0; i < 43; i++) pending_pixels.push_back($urandom);
      wait_drained();

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
